>>> hdl/terd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// terd_pkg: shared types and tables for the entity reference decoder
// Holds the command/status structs and the name ROM.
// ----------------------------------------------------------------------------
package terd_pkg;

	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CTRL_MAX = 8'd32;
	localparam int ROM_SIZE  = 115;
	localparam int KEY_MAX   = 8;
	localparam int TEXT_MAX  = 7;
	localparam int ROM_IDX_W = 7;

	// datapath operations commanded by the controller
	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD_IN,   // take the input byte into the work queue
		OP_POP,       // drop the head byte of the work queue
		OP_PUSH_LA,   // move head byte into the lookahead buffer
		OP_FAIL,      // prepend lookahead to the work queue, clear lookahead
		OP_CLEAR_LA   // clear the lookahead buffer
	} dp_op_t;

	typedef struct packed {
		dp_op_t          op;
		logic            rom_start;
	} dp_cmd_t;

	typedef struct packed {
		logic            work_empty;
		logic            work_one;
		logic [7:0]      head;
		logic            la_full;
		logic            la_empty;
		logic            rom_done;
		logic            rom_hit;
		logic [2:0]      text_len;
	} dp_stat_t;

	typedef struct packed {
		logic [63:0]      key;
		logic [3:0]       key_len;
		logic [55:0]      text;
		logic [2:0]       text_len;
	} rom_entry_t;

	function automatic logic [63:0] pk(input string s);
		logic [63:0] r;
		r = '0;
		for (int i = 0; i < s.len() && i < 8; i++) r[i*8 +: 8] = s[i];
		return r;
	endfunction

	function automatic rom_entry_t mk(input string k, input string t);
		rom_entry_t e;
		e.key      = pk(k);
		e.key_len  = 4'(k.len());
		e.text     = 56'(pk(t));
		e.text_len = 3'(t.len());
		return e;
	endfunction

	function automatic rom_entry_t rom_read(input logic [ROM_IDX_W-1:0] a);
		rom_entry_t e;
		unique case (a)
			7'd0: e = mk("nbsp"," ");        7'd1: e = mk("iexcl"," ");
			7'd2: e = mk("Agrave","A");      7'd3: e = mk("Aacute","A");
			7'd4: e = mk("Acirc","A");       7'd5: e = mk("Atilde","A");
			7'd6: e = mk("Auml","Ae");       7'd7: e = mk("Aring","A");
			7'd8: e = mk("AElig","Ae");      7'd9: e = mk("Ccedil","C");
			7'd10: e = mk("Egrave","E");     7'd11: e = mk("Eacute","E");
			7'd12: e = mk("Ecirc","E");      7'd13: e = mk("Euml","E");
			7'd14: e = mk("Igrave","I");     7'd15: e = mk("Iacute","I");
			7'd16: e = mk("Icirc","I");      7'd17: e = mk("Iuml","I");
			7'd18: e = mk("Ntilde","N");     7'd19: e = mk("Ograve","O");
			7'd20: e = mk("Oacute","O");     7'd21: e = mk("Ocirc","O");
			7'd22: e = mk("Otilde","O");     7'd23: e = mk("Ouml","Oe");
			7'd24: e = mk("Oslash","Oe");    7'd25: e = mk("Ugrave","U");
			7'd26: e = mk("Uacute","U");     7'd27: e = mk("Ucirc","U");
			7'd28: e = mk("Uuml","Ue");      7'd29: e = mk("Yacute","Y");
			7'd30: e = mk("szlig","ss");     7'd31: e = mk("aacute","a");
			7'd32: e = mk("acirc","a");      7'd33: e = mk("atilde","a");
			7'd34: e = mk("auml","ae");      7'd35: e = mk("aring","a");
			7'd36: e = mk("aelig","ae");     7'd37: e = mk("ccedil","c");
			7'd38: e = mk("egrave","e");     7'd39: e = mk("eacute","e");
			7'd40: e = mk("ecirc","e");      7'd41: e = mk("euml","e");
			7'd42: e = mk("igrave","i");     7'd43: e = mk("iacute","i");
			7'd44: e = mk("icirc","i");      7'd45: e = mk("iuml","i");
			7'd46: e = mk("ntilde","n");     7'd47: e = mk("ograve","o");
			7'd48: e = mk("oacute","o");     7'd49: e = mk("ocirc","o");
			7'd50: e = mk("otilde","o");     7'd51: e = mk("ouml","oe");
			7'd52: e = mk("oslash","oe");    7'd53: e = mk("ugrave","u");
			7'd54: e = mk("uacute","u");     7'd55: e = mk("ucirc","u");
			7'd56: e = mk("uuml","ue");      7'd57: e = mk("yacute","y");
			7'd58: e = mk("yuml","y");       7'd59: e = mk("OElig","Oe");
			7'd60: e = mk("oelig","oe");     7'd61: e = mk("Scaron","S");
			7'd62: e = mk("scaron","s");     7'd63: e = mk("euro","Euro");
			7'd64: e = mk("Alpha","Alpha");  7'd65: e = mk("Beta","Beta");
			7'd66: e = mk("Gamma","Gamma");  7'd67: e = mk("Delta","Delta");
			7'd68: e = mk("Epsilon","Epsilon"); 7'd69: e = mk("Zeta","Zeta");
			7'd70: e = mk("Eta","Eta");      7'd71: e = mk("Theta","Theta");
			7'd72: e = mk("Iota","Iota");    7'd73: e = mk("Kappa","Kappa");
			7'd74: e = mk("Lambda","Lambda"); 7'd75: e = mk("Mu","Mu");
			7'd76: e = mk("Nu","Nu");        7'd77: e = mk("Xi","Xi");
			7'd78: e = mk("Omicron","Omicron"); 7'd79: e = mk("Pi","Pi");
			7'd80: e = mk("Rho","Rho");      7'd81: e = mk("Sigma","Sigma");
			7'd82: e = mk("Tau","Tau");      7'd83: e = mk("Upsilon","Upsilon");
			7'd84: e = mk("Phi","Phi");      7'd85: e = mk("Chi","Chi");
			7'd86: e = mk("Psi","Psi");      7'd87: e = mk("Omega","Omega");
			7'd88: e = mk("alpha","alpha");  7'd89: e = mk("beta","beta");
			7'd90: e = mk("gamma","gamma");  7'd91: e = mk("delta","delta");
			7'd92: e = mk("epsilon","epsilon"); 7'd93: e = mk("zeta","zeta");
			7'd94: e = mk("eta","eta");      7'd95: e = mk("theta","theta");
			7'd96: e = mk("iota","iota");    7'd97: e = mk("kappa","kappa");
			7'd98: e = mk("lambda","lambda"); 7'd99: e = mk("mu","mu");
			7'd100: e = mk("nu","nu");       7'd101: e = mk("xi","xi");
			7'd102: e = mk("omicron","omicron"); 7'd103: e = mk("pi","pi");
			7'd104: e = mk("rho","rho");     7'd105: e = mk("sigma","sigma");
			7'd106: e = mk("tau","tau");     7'd107: e = mk("upsilon","upsilon");
			7'd108: e = mk("phi","phi");     7'd109: e = mk("chi","chi");
			7'd110: e = mk("psi","psi");     7'd111: e = mk("omega","omega");
			7'd112: e = mk("thetasym","theta"); 7'd113: e = mk("upsih","upsilon");
			7'd114: e = mk("piv","pi");
			default: e = '0;
		endcase
		return e;
	endfunction

endpackage

>>> hdl/terd_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// terd_datapath: work queue, lookahead buffer and ROM search
// Holds bytes still to scan, the pending name, and walks the name ROM.
// ----------------------------------------------------------------------------
module terd_datapath import terd_pkg::*; #(
	parameter int DEPTH = 9
) (
	input  logic             clk,
	input  logic             arst_n,
	input  dp_cmd_t          cmd,
	input  logic [7:0]       in_byte,
	input  logic [2:0]       text_sel,
	output dp_stat_t         stat,
	output logic [7:0]       text_byte
);
	localparam int WQ   = DEPTH + 2;
	localparam int WQ_W = $clog2(WQ + 1);
	localparam int LA_W = $clog2(DEPTH + 1);

	logic [7:0]          work_q [WQ];
	logic [WQ_W-1:0]     wcnt_q;
	logic [7:0]          la_q [DEPTH];
	logic [LA_W-1:0]     lcnt_q;
	logic [ROM_IDX_W-1:0] ridx_q;
	logic                rbusy_q, rdone_q, rhit_q;
	logic [55:0]         rtext_q;
	logic [2:0]          rlen_q;
	rom_entry_t          ent;
	logic                key_eq;

	assign ent = rom_read(ridx_q);

	always_comb begin
		key_eq = (ent.key_len == 4'(lcnt_q));
		for (int i = 0; i < KEY_MAX; i++) begin
			if (i < DEPTH && 4'(i) < ent.key_len && la_q[i] != ent.key[i*8 +: 8]) key_eq = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wcnt_q  <= '0;
			lcnt_q  <= '0;
			rbusy_q <= 1'b0;
			rdone_q <= 1'b0;
			rhit_q  <= 1'b0;
			ridx_q  <= '0;
		end else begin
			unique case (cmd.op)
				OP_LOAD_IN: begin
					work_q[0] <= in_byte;
					wcnt_q    <= WQ_W'(1);
				end
				OP_POP: begin
					for (int i = 0; i < WQ - 1; i++) work_q[i] <= work_q[i+1];
					wcnt_q <= wcnt_q - 1'b1;
				end
				OP_PUSH_LA: begin
					la_q[lcnt_q[LA_W-1:0]] <= work_q[0];
					lcnt_q <= lcnt_q + 1'b1;
					for (int i = 0; i < WQ - 1; i++) work_q[i] <= work_q[i+1];
					wcnt_q <= wcnt_q - 1'b1;
				end
				OP_FAIL: begin
					// head stays, lookahead goes in front
					for (int i = 0; i < WQ; i++) begin
						if (i < int'(lcnt_q)) work_q[i] <= la_q[i];
						else if (i - int'(lcnt_q) < WQ) work_q[i] <= work_q[i - int'(lcnt_q)];
					end
					wcnt_q <= (int'(wcnt_q) + int'(lcnt_q) > WQ) ? WQ_W'(WQ)
					          : WQ_W'(wcnt_q + lcnt_q);
					lcnt_q <= '0;
				end
				OP_CLEAR_LA: lcnt_q <= '0;
				default: ;
			endcase
			// done and hit stay up until the next walk starts
			if (cmd.rom_start) begin
				ridx_q  <= '0;
				rbusy_q <= 1'b1;
				rdone_q <= 1'b0;
				rhit_q  <= 1'b0;
			end else if (rbusy_q) begin
				if (key_eq) begin
					rbusy_q <= 1'b0;
					rdone_q <= 1'b1;
					rhit_q  <= 1'b1;
					rtext_q <= ent.text;
					rlen_q  <= ent.text_len;
				end else if (ridx_q == ROM_IDX_W'(ROM_SIZE - 1)) begin
					rbusy_q <= 1'b0;
					rdone_q <= 1'b1;
				end else begin
					ridx_q <= ridx_q + 1'b1;
				end
			end
		end
	end

	assign stat.work_empty = (wcnt_q == '0);
	assign stat.work_one   = (wcnt_q == WQ_W'(1));
	assign stat.head       = work_q[0];
	assign stat.la_full    = (int'(lcnt_q) + 1 >= DEPTH);
	assign stat.la_empty   = (lcnt_q == '0);
	assign stat.rom_done   = rdone_q;
	assign stat.rom_hit    = rhit_q;
	assign stat.text_len   = rlen_q;
	assign text_byte       = rtext_q[text_sel*8 +: 8];

endmodule

>>> hdl/terd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// terd_ctrl: scan controller
// Steps through queued bytes, decides copy, hold, resolve or replay.
// ----------------------------------------------------------------------------
module terd_ctrl import terd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        in_last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_data,
	output logic        out_end,
	input  dp_stat_t    stat,
	input  logic [7:0]  text_byte,
	output dp_cmd_t     cmd,
	output logic [2:0]  text_sel
);
	typedef enum logic [2:0] {ST_IDLE, ST_SCAN, ST_ROM_WAIT, ST_TEXT, ST_FLUSH} st_t;

	st_t        st_q;
	logic       inref_q, last_q;
	logic [2:0] tix_q;
	logic       ov_q;
	logic [7:0] ob_q;
	logic       ol_q;
	logic       slot_free;
	logic       emit;
	logic [7:0] emit_b;
	logic       emit_last;  // this beat ends the string

	assign slot_free = !ov_q || !out_stall;
	assign in_stall  = !(st_q == ST_IDLE && slot_free);

	// work commands and an output beat for this cycle
	always_comb begin
		cmd.op        = OP_NONE;
		cmd.rom_start = 1'b0;
		emit          = 1'b0;
		emit_b        = stat.head;
		emit_last     = 1'b0;
		unique case (st_q)
			ST_IDLE: if (in_valid && slot_free) cmd.op = OP_LOAD_IN;
			ST_SCAN: if (slot_free && !stat.work_empty) begin
				if (!inref_q) begin
					cmd.op = OP_POP;
					if (stat.head != CH_AMP) begin
						emit      = 1'b1;
						emit_last = last_q && stat.work_one;
					end
				end else if (stat.head == CH_SEMI) begin
					cmd.op = OP_POP;
					cmd.rom_start = 1'b1;
				end else if (stat.head <= CTRL_MAX || stat.la_full) begin
					cmd.op = OP_FAIL;
					emit   = 1'b1;
					emit_b = CH_SPACE;
				end else begin
					cmd.op = OP_PUSH_LA;
				end
			end
			ST_ROM_WAIT: if (stat.rom_done && !stat.rom_hit && slot_free) begin
				emit = 1'b1;
				emit_b = CH_SPACE;
				emit_last = last_q && stat.work_empty;
				cmd.op = OP_CLEAR_LA;
			end
			ST_TEXT: if (slot_free) begin
				emit = 1'b1;
				emit_b = text_byte;
				if (tix_q + 1'b1 == stat.text_len) begin
					cmd.op = OP_CLEAR_LA;
					emit_last = last_q && stat.work_empty;
				end
			end
			ST_FLUSH: if (slot_free) begin
				cmd.op = OP_FAIL;
				emit   = 1'b1;
				emit_b = CH_SPACE;
				emit_last = last_q && stat.la_empty;
			end
			default: ;
		endcase
	end

	assign text_sel = tix_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			inref_q <= 1'b0;
			last_q  <= 1'b0;
			tix_q   <= '0;
			ov_q    <= 1'b0;
			ol_q    <= 1'b0;
		end else begin
			if (ov_q && !out_stall) ov_q <= 1'b0;
			if (emit) begin
				ov_q <= 1'b1;
				ob_q <= emit_b;
				ol_q <= emit_last;
			end
			unique case (st_q)
				ST_IDLE: if (cmd.op == OP_LOAD_IN) begin
					last_q <= in_last;
					st_q   <= ST_SCAN;
				end
				ST_SCAN: if (stat.work_empty) begin
					if (last_q && inref_q) st_q <= ST_FLUSH;
					else begin
						st_q <= ST_IDLE;
						if (last_q) inref_q <= 1'b0;
					end
				end else if (slot_free) begin
					if (!inref_q) begin
						if (stat.head == CH_AMP) inref_q <= 1'b1;
					end else if (stat.head == CH_SEMI) begin
						st_q <= ST_ROM_WAIT;
					end else if (cmd.op == OP_FAIL) begin
						inref_q <= 1'b0;
					end
				end
				ST_ROM_WAIT: if (stat.rom_done) begin
					if (stat.rom_hit) begin
						st_q <= ST_TEXT;
						tix_q <= '0;
					end else if (slot_free) begin
						inref_q <= 1'b0;
						st_q <= ST_SCAN;
					end
				end
				ST_TEXT: if (slot_free) begin
					tix_q <= tix_q + 1'b1;
					if (tix_q + 1'b1 == stat.text_len) begin
						inref_q <= 1'b0;
						st_q <= ST_SCAN;
					end
				end
				ST_FLUSH: if (slot_free) begin
					inref_q <= 1'b0;
					st_q <= ST_SCAN;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = ov_q;
	assign out_data  = ob_q;
	assign out_end   = ol_q;

`ifndef SYNTHESIS
	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> slot_free) else $error("beat emitted into a full slot");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != ST_IDLE) |-> in_stall) else $error("input taken while busy");
	a_text_from_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_TEXT) |-> stat.rom_hit) else $error("text without ROM hit");
`endif

endmodule

>>> hdl/text_entity_reference_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_entity_reference_decoder: copy text, replacing entity references
// Controller plus datapath; names resolved by a walk over a 115-entry ROM.
// ----------------------------------------------------------------------------
// channel | handshake          | payload
// in      | in_valid/in_stall  | data_byte, is_last
// out     | out_valid/out_stall| out_byte, out_last
//
// An ordinary byte is loaded, scanned, then the controller returns to idle.
// A ';' starts a ROM walk of one entry a cycle, then the text bytes go out
// one a cycle while the output is not stalled. A reference broken off before
// ';' replays up to LOOKAHEAD_DEPTH-1 held bytes, one a cycle when unstalled.
// Reset clears control state; the lookahead contents are not cleared.
// A stalled output holds the beat and freezes the scan.
// ----------------------------------------------------------------------------
module text_entity_reference_decoder import terd_pkg::*; #(
	parameter int LOOKAHEAD_DEPTH = 9
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       is_last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       out_last
);
	dp_cmd_t    cmd;
	dp_stat_t   stat;
	logic [7:0] text_byte;
	logic [2:0] text_sel;

	// datapath: queue, lookahead, ROM search
	terd_datapath #(.DEPTH(LOOKAHEAD_DEPTH)) u_dp (
		.clk, .arst_n, .cmd, .in_byte(data_byte), .text_sel, .stat, .text_byte
	);

	// controller: drives handshakes and commands
	terd_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .in_last(is_last),
		.out_valid, .out_stall, .out_data(out_byte), .out_end(out_last),
		.stat, .text_byte, .cmd, .text_sel
	);

endmodule
